// ----- rtl/core/mktd_pkg.sv -----
// Package for the Morse key timing decoder: register codes, reset values,
// result and transfer types, and the A-Z code table. No dependencies.
`default_nettype none

package mktd_pkg;

  localparam int unsigned MaxSymbolsDef = 4;
  localparam int unsigned TimerWidthDef = 16;
  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CodeWidth     = 7;
  localparam int unsigned OutDepth      = 4;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DOT_LIMIT  = 3'd0,
    REG_DASH_LIMIT = 3'd1,
    REG_END_HOLD   = 3'd2,
    REG_LETTER_GAP = 3'd3,
    REG_WORD_GAP   = 3'd4
  } cfg_reg_e;

  localparam logic [CfgWidth-1:0] DotLimitRst  = 16'd200;
  localparam logic [CfgWidth-1:0] DashLimitRst = 16'd500;
  localparam logic [CfgWidth-1:0] EndHoldRst   = 16'd1500;
  localparam logic [CfgWidth-1:0] LetterGapRst = 16'd1000;
  localparam logic [CfgWidth-1:0] WordGapRst   = 16'd2500;

  localparam logic [CodeWidth-1:0] CharNone  = 7'd0;
  localparam logic [CodeWidth-1:0] CharSpace = 7'd32;

  typedef struct packed {
    logic [CfgWidth-1:0] dot_limit;
    logic [CfgWidth-1:0] dash_limit;
    logic [CfgWidth-1:0] end_hold;
    logic [CfgWidth-1:0] letter_gap;
    logic [CfgWidth-1:0] word_gap;
  } cfg_t;

  typedef struct packed {
    logic [CodeWidth-1:0] char_code;
    logic                 char_valid;
    logic                 message_end;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [CodeWidth-1:0] code_letter(input logic [4:0] idx);
    logic [CodeWidth-1:0] ch;
    case (idx)
      5'd2:    ch = 7'h45;
      5'd3:    ch = 7'h54;
      5'd4:    ch = 7'h49;
      5'd5:    ch = 7'h41;
      5'd6:    ch = 7'h4E;
      5'd7:    ch = 7'h4D;
      5'd8:    ch = 7'h53;
      5'd9:    ch = 7'h55;
      5'd10:   ch = 7'h52;
      5'd11:   ch = 7'h57;
      5'd12:   ch = 7'h44;
      5'd13:   ch = 7'h4B;
      5'd14:   ch = 7'h47;
      5'd15:   ch = 7'h4F;
      5'd16:   ch = 7'h48;
      5'd17:   ch = 7'h56;
      5'd18:   ch = 7'h46;
      5'd20:   ch = 7'h4C;
      5'd22:   ch = 7'h50;
      5'd23:   ch = 7'h4A;
      5'd24:   ch = 7'h42;
      5'd25:   ch = 7'h58;
      5'd26:   ch = 7'h43;
      5'd27:   ch = 7'h59;
      5'd28:   ch = 7'h5A;
      5'd29:   ch = 7'h51;
      default: ch = CharNone;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mktd_if.sv -----
// Channel interfaces of the Morse key timing decoder: key samples, decoded
// results and register writes. Depends on mktd_pkg.
`default_nettype none

interface mktd_key_if;
  logic valid;
  logic ready;
  logic key_down;
  modport source (output valid, output key_down, input ready);
  modport sink (input valid, input key_down, output ready);
endinterface

interface mktd_res_if;
  logic                           valid;
  logic                           ready;
  logic [mktd_pkg::CodeWidth-1:0] char_code;
  logic                           char_valid;
  logic                           message_end;
  modport source (output valid, output char_code, output char_valid, output message_end,
                  input ready);
  modport sink (input valid, input char_code, input char_valid, input message_end,
                output ready);
endinterface

interface mktd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mktd_pkg::CfgIdxWidth-1:0] index;
  logic [mktd_pkg::CfgWidth-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/morse_key_timing_decoder.sv -----
// Morse key timing decoder, top level.
// Channels: key_i takes one key sample per millisecond tick (key_down, 1 =
// pressed); res_o delivers decoded results (char_code, char_valid,
// message_end); cfg_i writes the five 16-bit thresholds by index (dot_limit,
// dash_limit, end_hold, letter_gap, word_gap), always ready.
// Each key sample yields zero, one or two results: a letter and/or a space
// at the start of a press, or a final result with message_end on a release
// that follows a press longer than end_hold.
// A result's sample passes through the sample register and the decode logic into
// the result queue before the result shows on res_o.
// Throughput: one sample per cycle while the result queue has room, set by the
// combinational timer and decode logic behind the sample register; a four-entry
// result queue decouples the two sides.
// A stalled res_o fills the queue; key_i.ready drops when fewer than two
// entries are free and the sample register is occupied.
// Reset: thresholds return to their defaults (200, 500, 1500, 1000, 2500),
// the gap timer starts saturated, pending symbols clear and the queue empties.
// Depends on mktd_pkg, mktd_if, mktd_cfg_regs, mktd_core and mktd_out_fifo.
`default_nettype none

module morse_key_timing_decoder #(
  parameter int unsigned MAX_SYMBOLS = mktd_pkg::MaxSymbolsDef,
  parameter int unsigned TIMER_WIDTH = mktd_pkg::TimerWidthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mktd_key_if.sink   key_i,
  mktd_res_if.source res_o,
  mktd_cfg_if.sink   cfg_i
);

  mktd_pkg::cfg_t  cfg;
  mktd_pkg::push_t push;
  logic            room;

  mktd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mktd_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_i),
    .cfg_i  (cfg),
    .room_i (room),
    .push_o (push)
  );

  mktd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mktd_cfg_regs.sv -----
// Timing threshold registers of the Morse key timing decoder.
// Depends on mktd_pkg and mktd_cfg_if.
`default_nettype none

module mktd_cfg_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  mktd_cfg_if.sink            cfg_i,
  output mktd_pkg::cfg_t      cfg_o
);

  mktd_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_limit  <= mktd_pkg::DotLimitRst;
      cfg_q.dash_limit <= mktd_pkg::DashLimitRst;
      cfg_q.end_hold   <= mktd_pkg::EndHoldRst;
      cfg_q.letter_gap <= mktd_pkg::LetterGapRst;
      cfg_q.word_gap   <= mktd_pkg::WordGapRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mktd_pkg::REG_DOT_LIMIT:  cfg_q.dot_limit  <= cfg_i.data;
        mktd_pkg::REG_DASH_LIMIT: cfg_q.dash_limit <= cfg_i.data;
        mktd_pkg::REG_END_HOLD:   cfg_q.end_hold   <= cfg_i.data;
        mktd_pkg::REG_LETTER_GAP: cfg_q.letter_gap <= cfg_i.data;
        mktd_pkg::REG_WORD_GAP:   cfg_q.word_gap   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mktd_core.sv -----
// Key sample register, press/gap timers, pending symbol state and letter
// decode. Depends on mktd_pkg and mktd_key_if.
`default_nettype none

module mktd_core #(
  parameter int unsigned MAX_SYMBOLS = mktd_pkg::MaxSymbolsDef,
  parameter int unsigned TIMER_WIDTH = mktd_pkg::TimerWidthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  mktd_key_if.sink            key_i,
  input  mktd_pkg::cfg_t      cfg_i,
  input  wire logic           room_i,
  output mktd_pkg::push_t     push_o
);

  localparam int unsigned CntW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned CmpW = (TIMER_WIDTH > mktd_pkg::CfgWidth) ? TIMER_WIDTH
                                                                     : mktd_pkg::CfgWidth;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  logic                   in_valid_q;
  logic                   key_q;
  logic                   advance;

  logic                   was_down_q, was_down_d;
  logic [TIMER_WIDTH-1:0] held_q, held_d;
  logic [TIMER_WIDTH-1:0] idle_q, idle_d;
  logic [MAX_SYMBOLS-1:0] bits_q, bits_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic                   mhs_q, mhs_d;

  function automatic logic [mktd_pkg::CodeWidth-1:0] decode(
    input logic [MAX_SYMBOLS-1:0] bits,
    input logic [CntW-1:0]        cnt,
    input logic                   ovf
  );
    logic [4:0] one_hot;
    logic [4:0] idx;
    one_hot = 5'd1 << cnt[2:0];
    idx     = one_hot | ({1'b0, bits[3:0]} & (one_hot - 5'd1));
    if (ovf || cnt == '0 || cnt > CntW'(4)) begin
      return mktd_pkg::CharNone;
    end
    return mktd_pkg::code_letter(idx);
  endfunction

  assign advance     = in_valid_q & room_i;
  assign key_i.ready = ~in_valid_q | room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (key_i.valid && key_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      key_q <= key_i.key_down;
    end
  end

  always_comb begin
    mktd_pkg::res_t         r;
    logic [CmpW-1:0]        gap;
    logic [CmpW-1:0]        dur;
    logic                   letter_hit;
    logic                   add;
    logic [mktd_pkg::CodeWidth-1:0] ch;
    gap        = CmpW'(idle_q);
    dur        = CmpW'(held_q);
    letter_hit = 1'b0;
    add        = 1'b0;
    ch         = mktd_pkg::CharNone;
    r          = '0;
    was_down_d = was_down_q;
    held_d     = held_q;
    idle_d     = idle_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    mhs_d      = mhs_q;
    push_o     = '0;
    if (advance) begin
      was_down_d = key_q;
      if (key_q) begin
        if (!was_down_q) begin
          letter_hit = (gap > CmpW'(cfg_i.letter_gap)) && (cnt_q != '0);
          ch         = decode(bits_q, cnt_q, ovf_q);
          if (letter_hit) begin
            if (ch != mktd_pkg::CharNone) begin
              r.char_code   = ch;
              r.char_valid  = 1'b1;
              push_o.first  = r;
              push_o.num    = 2'd1;
            end
            bits_d = '0;
            cnt_d  = '0;
            ovf_d  = 1'b0;
          end
          if (gap >= CmpW'(cfg_i.word_gap) && mhs_q) begin
            r.char_code  = mktd_pkg::CharSpace;
            r.char_valid = 1'b1;
            if (push_o.num == 2'd0) begin
              push_o.first = r;
            end else begin
              push_o.second = r;
            end
            push_o.num = push_o.num + 2'd1;
          end
          held_d = TIMER_WIDTH'(1);
        end else begin
          held_d = (held_q == TimerMax) ? held_q : held_q + TIMER_WIDTH'(1);
        end
      end else begin
        if (was_down_q) begin
          if (dur < CmpW'(cfg_i.dot_limit)) begin
            add = 1'b1;
          end else if (dur < CmpW'(cfg_i.dash_limit)) begin
            add = 1'b1;
          end
          if (add) begin
            if (ovf_q || cnt_q >= CntW'(MAX_SYMBOLS)) begin
              ovf_d = 1'b1;
            end else begin
              bits_d = {bits_q[MAX_SYMBOLS-2:0], ~(dur < CmpW'(cfg_i.dot_limit))};
              cnt_d  = cnt_q + CntW'(1);
            end
            mhs_d = 1'b1;
          end
          if (dur > CmpW'(cfg_i.end_hold)) begin
            ch            = decode(bits_d, cnt_d, ovf_d);
            r.char_code   = ch;
            r.char_valid  = (ch != mktd_pkg::CharNone);
            r.message_end = 1'b1;
            push_o.first  = r;
            push_o.num    = 2'd1;
            bits_d        = '0;
            cnt_d         = '0;
            ovf_d         = 1'b0;
            mhs_d         = 1'b0;
          end
          idle_d = TIMER_WIDTH'(1);
        end else begin
          idle_d = (idle_q == TimerMax) ? idle_q : idle_q + TIMER_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q <= 1'b0;
      held_q     <= '0;
      idle_q     <= TimerMax;
      bits_q     <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      mhs_q      <= 1'b0;
    end else begin
      was_down_q <= was_down_d;
      held_q     <= held_d;
      idle_q     <= idle_d;
      bits_q     <= bits_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      mhs_q      <= mhs_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mktd_out_fifo.sv -----
// Result queue of the Morse key timing decoder: takes up to two results per
// cycle and hands out one per transaction. Depends on mktd_pkg and mktd_res_if.
`default_nettype none

module mktd_out_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  mktd_pkg::push_t     push_i,
  output logic                room_o,
  mktd_res_if.source          res_o
);

  localparam int unsigned Depth = mktd_pkg::OutDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mktd_pkg::res_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign pop              = res_o.valid & res_o.ready;
  assign room_o           = cnt_q <= CntW'(Depth - 2);
  assign res_o.valid      = cnt_q != '0;
  assign res_o.char_code  = mem_q[rd_q].char_code;
  assign res_o.char_valid = mem_q[rd_q].char_valid;
  assign res_o.message_end = mem_q[rd_q].message_end;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.num);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mktd_checker.sv -----
// Port checker for the Morse key timing decoder, bound to the top level.
// Depends on mktd_pkg and morse_key_timing_decoder.
`default_nettype none

module mktd_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           res_valid_i,
  input wire logic                           res_ready_i,
  input wire logic [mktd_pkg::CodeWidth-1:0] char_code_i,
  input wire logic                           char_valid_i,
  input wire logic                           message_end_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !res_valid_i)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(char_code_i)
                                   && $stable(char_valid_i) && $stable(message_end_i))
    else $error("stalled result changed");

  a_empty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !char_valid_i |-> char_code_i == mktd_pkg::CharNone && message_end_i)
    else $error("result without character is not a bare message end");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && char_valid_i |-> char_code_i == mktd_pkg::CharSpace
                                    || (char_code_i >= 7'h41 && char_code_i <= 7'h5A))
    else $error("character outside A-Z and space");

  a_space_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && char_code_i == mktd_pkg::CharSpace |-> !message_end_i)
    else $error("space carries message end");

endmodule

bind morse_key_timing_decoder mktd_checker u_mktd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .char_code_i   (res_o.char_code),
  .char_valid_i  (res_o.char_valid),
  .message_end_i (res_o.message_end)
);

`default_nettype wire
